// ===== hw/rtl/pbme_pkg.sv =====
package pbme_pkg;

   localparam int DATA_W  = 32;
   localparam int PHASE_W = 16;
   localparam int BSIZE_W = 5;
   localparam int LIMIT_W = 16;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   // request kinds carried on req_tuser
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_FLUSH  = 1'b1;

   // register indexes, byte address = 4 * index
   localparam logic [1:0] REG_BATCH_SIZE  = 2'd0;
   localparam logic [1:0] REG_PERIOD      = 2'd1;
   localparam logic [1:0] REG_BATCH_LIMIT = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_PHASE,
      ST_TRY,
      ST_EMIT_RD,
      ST_EMIT_WAIT,
      ST_EMIT_OUT
   } state_type;

endpackage

// ===== hw/rtl/periodic_batch_min_extractor.sv =====
// Periodic batch minimum extractor.
// req_* : input items. tuser = mode (0 insert, 1 flush), tdata = signed value.
//   An insert places the value in a sorted store (ring buffer in one RAM);
//   every period-th insert, and every flush, tries to pop one batch.
// rsp_* : result items. tdata = extracted value, tlast on the last of a batch.
//   A batch is the batch_size smallest stored values, ascending.
// csr_* : three registers at 0x0 batch_size, 0x4 period, 0x8 batch_limit.
//   Writing batch_limit also reloads the remaining batch count.
// Flow: req_tready is high only while idle. An insert reads each stored
//   entry larger than the new value and, through the single comparator,
//   compares it and writes it one place up, then writes the new value; a
//   full store drops the value at once. Then the phase is stepped in its
//   own state. A flush goes straight to its attempt. For each value
//   emitted the attempt then does a RAM read, registers the read data and
//   loads the output register, then waits while the receiver holds
//   rsp_tready low. Under stall the result is held in the output register
//   and nothing else moves.
// Reset: store emptied, phase cleared, batch_size 1, period 1, batch_limit 0
//   (so no batch is emitted until batch_limit is written).
module periodic_batch_min_extractor import pbme_pkg::*; #(
   parameter int STORE_DEPTH = 256,
   parameter int MAX_BATCH   = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,   // [31:0] value
   input  logic              req_tuser,   // [0] mode
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,   // [31:0] out_value
   output logic              rsp_tlast,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam int KW = $clog2(MAX_BATCH + 1);

   logic [BSIZE_W-1:0]       batch_size_ff, batch_size_in;
   logic [PHASE_W-1:0]       period_ff, period_in;
   logic [LIMIT_W-1:0]       batch_limit_ff, batch_limit_in;
   logic [LIMIT_W-1:0]       batches_left_ff, batches_left_in;

   logic                     csr_wr;
   logic [1:0]               csr_idx;
   logic [KW-1:0]            batch_k;
   logic [PHASE_W-1:0]       period_eff;
   logic                     take_batch;
   logic signed [DATA_W-1:0] rsp_value;

   logic                     mem_wr_en;
   logic [AW-1:0]            mem_wr_addr;
   logic signed [DATA_W-1:0] mem_wr_data;
   logic                     mem_rd_en;
   logic [AW-1:0]            mem_rd_addr;
   logic signed [DATA_W-1:0] mem_rd_data;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_idx)
         REG_BATCH_SIZE:  csr_prdata = CSR_DW'(batch_size_ff);
         REG_PERIOD:      csr_prdata = CSR_DW'(period_ff);
         REG_BATCH_LIMIT: csr_prdata = CSR_DW'(batch_limit_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_comb begin
      batch_size_in   = batch_size_ff;
      period_in       = period_ff;
      batch_limit_in  = batch_limit_ff;
      batches_left_in = batches_left_ff;
      if (take_batch) begin
         batches_left_in = batches_left_ff - 1'b1;
      end
      if (csr_wr) begin
         case (csr_idx)
            REG_BATCH_SIZE:  batch_size_in = csr_pwdata[BSIZE_W-1:0];
            REG_PERIOD:      period_in     = csr_pwdata[PHASE_W-1:0];
            REG_BATCH_LIMIT: begin
               batch_limit_in  = csr_pwdata[LIMIT_W-1:0];
               batches_left_in = csr_pwdata[LIMIT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_size_ff   <= BSIZE_W'(1);
         period_ff       <= PHASE_W'(1);
         batch_limit_ff  <= '0;
         batches_left_ff <= '0;
      end else begin
         batch_size_ff   <= batch_size_in;
         period_ff       <= period_in;
         batch_limit_ff  <= batch_limit_in;
         batches_left_ff <= batches_left_in;
      end
   end

   // zero acts as one, oversize clamps to the batch buffer limit
   always_comb begin
      if (batch_size_ff == '0) begin
         batch_k = KW'(1);
      end else if (32'(batch_size_ff) > 32'(MAX_BATCH)) begin
         batch_k = KW'(MAX_BATCH);
      end else begin
         batch_k = KW'(batch_size_ff);
      end
   end

   assign period_eff = (period_ff == '0) ? PHASE_W'(1) : period_ff;

   pbme_ctrl #(
      .DEPTH (STORE_DEPTH),
      .AW    (AW),
      .CW    (CW),
      .KW    (KW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_mode      (req_tuser),
      .req_value     (req_tdata),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_value     (rsp_value),
      .rsp_last      (rsp_tlast),
      .batch_k       (batch_k),
      .period_eff    (period_eff),
      .batches_avail (batches_left_ff != '0),
      .take_batch    (take_batch),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data)
   );

   assign rsp_tdata = rsp_value;

   pbme_store #(
      .DEPTH (STORE_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

`ifndef ASSERT_OFF
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a result is pending");

   a_take_needs_budget: assert property (@(posedge clock) disable iff (reset)
      take_batch |-> (batches_left_ff != '0))
      else $error("batch taken with no batches left");

   a_last_ends_batch: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> !rsp_tvalid)
      else $error("result follows the last item of a batch at once");

   a_limit_reload: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && csr_idx == REG_BATCH_LIMIT)
      |=> (batches_left_ff == $past(csr_pwdata[LIMIT_W-1:0])))
      else $error("batch count not reloaded by limit write");
`endif

endmodule

// ===== hw/rtl/pbme_store.sv =====
module pbme_store import pbme_pkg::*; #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic signed [DATA_W-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr,
   output logic signed [DATA_W-1:0] rd_data
);

   logic signed [DATA_W-1:0] mem_ff [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/pbme_ctrl.sv =====
module pbme_ctrl import pbme_pkg::*; #(
   parameter int DEPTH = 256,
   parameter int AW    = 8,
   parameter int CW    = 9,
   parameter int KW    = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_mode,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_value,
   output logic                     rsp_last,
   input  logic [KW-1:0]            batch_k,
   input  logic [PHASE_W-1:0]       period_eff,
   input  logic                     batches_avail,
   output logic                     take_batch,
   output logic                     mem_wr_en,
   output logic [AW-1:0]            mem_wr_addr,
   output logic signed [DATA_W-1:0] mem_wr_data,
   output logic                     mem_rd_en,
   output logic [AW-1:0]            mem_rd_addr,
   input  logic signed [DATA_W-1:0] mem_rd_data
);

   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam int SW = CW + 1;
   localparam int MW = (CW > KW) ? CW : KW;

   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [AW-1:0]            head_ff, head_in;
   logic [AW-1:0]            pos_ff, pos_in;
   logic [AW-1:0]            wr_addr_ff, wr_addr_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic [PHASE_W-1:0]       phase_ff, phase_in;
   logic [KW-1:0]            remain_ff, remain_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     store_full;
   logic [SW-1:0]            tail_sum;
   logic [AW-1:0]            tail_addr;
   logic [AW-1:0]            wr_addr_dec;
   logic [PHASE_W:0]         phase_next;
   logic                     phase_hit;
   logic                     batch_ok;
   logic                     entry_above;

   assign store_full  = (count_ff == CW'(DEPTH));
   assign tail_sum    = SW'(head_ff) + SW'(count_ff);
   assign tail_addr   = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
   assign wr_addr_dec = (wr_addr_ff == '0) ? LAST_ADDR : wr_addr_ff - 1'b1;
   assign phase_next  = {1'b0, phase_ff} + 1'b1;
   assign phase_hit   = (phase_next >= {1'b0, period_eff});
   assign batch_ok    = batches_avail && (MW'(count_ff) >= MW'(batch_k));
   // the shared comparator: stored entry against the key being placed
   assign entry_above = (mem_rd_data > key_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == MODE_FLUSH) begin
                  state_in = ST_TRY;
               end else if (!store_full) begin
                  state_in = ST_INS_RD;
               end else begin
                  state_in = ST_PHASE;
               end
            end
         end
         ST_INS_RD: begin
            state_in = (pos_ff == '0) ? ST_PHASE : ST_INS_CMP;
         end
         ST_INS_CMP: begin
            state_in = entry_above ? ST_INS_RD : ST_PHASE;
         end
         ST_PHASE: begin
            state_in = phase_hit ? ST_TRY : ST_IDLE;
         end
         ST_TRY: begin
            state_in = batch_ok ? ST_EMIT_RD : ST_IDLE;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (rsp_ready) begin
               state_in = (remain_ff == '0) ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      head_in      = head_ff;
      pos_in       = pos_ff;
      wr_addr_in   = wr_addr_ff;
      key_in       = key_ff;
      phase_in     = phase_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      req_ready    = 1'b0;
      take_batch   = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = wr_addr_ff;
      mem_wr_data  = key_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = wr_addr_dec;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               key_in     = req_value;
               pos_in     = count_ff[AW-1:0];
               wr_addr_in = tail_addr;
            end
         end
         ST_INS_RD: begin
            if (pos_ff == '0) begin
               mem_wr_en = 1'b1;
               count_in  = count_ff + 1'b1;
            end else begin
               mem_rd_en = 1'b1;
            end
         end
         ST_INS_CMP: begin
            mem_wr_en = 1'b1;
            if (entry_above) begin
               // shift the larger entry up one place
               mem_wr_data = mem_rd_data;
               wr_addr_in  = wr_addr_dec;
               pos_in      = pos_ff - 1'b1;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_PHASE: begin
            phase_in = phase_hit ? '0 : phase_next[PHASE_W-1:0];
         end
         ST_TRY: begin
            if (batch_ok) begin
               take_batch = 1'b1;
               remain_in  = batch_k;
            end
         end
         ST_EMIT_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = head_ff;
         end
         ST_EMIT_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = mem_rd_data;
            rsp_last_in  = (remain_ff == KW'(1));
            head_in      = (head_ff == LAST_ADDR) ? '0 : head_ff + 1'b1;
            count_in     = count_ff - 1'b1;
            remain_in    = remain_ff - 1'b1;
         end
         ST_EMIT_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      wr_addr_ff   <= wr_addr_in;
      key_ff       <= key_in;
      remain_ff    <= remain_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import pbme_pkg::*;

   localparam int STORE_DEPTH   = 256;
   localparam int MAX_BATCH     = 16;
   localparam int SETTLE_CYCLES = 2 * STORE_DEPTH + 40;
   localparam int QUIET_LIMIT   = 8000;
   localparam int LONG_HOLD     = 400;
   localparam int IDLE_PCT      = 17;
   localparam int MAX_REPORTS   = 40;

   typedef struct packed {
      logic              mode;
      logic [DATA_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              last;
   } min_result_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [31:0]       req_tdata;   // [31:0] value
   logic              req_tuser;   // [0] mode
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [31:0]       rsp_tdata;   // [31:0] out_value
   logic              rsp_tlast;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   // predictor state
   logic signed [DATA_W-1:0] sorted_vals[$];
   min_result_type           pending_mins[$];
   logic [BSIZE_W-1:0]       bsize_reg;
   logic [PHASE_W-1:0]       period_reg;
   logic [PHASE_W-1:0]       req_phase;
   logic [LIMIT_W-1:0]       batches_left;

   req_item_type send_q[$];
   bit        req_accepted;
   bit        calm;
   int        stall_token;
   int        stall_seen;
   int        hold_left;
   int        quiet_cycles;
   int        errors;
   int        n_inserts;
   int        n_flushes;
   int        n_dropped;
   int        n_results;
   int        n_batches;
   int        peak_fill;

   periodic_batch_min_extractor #(
      .STORE_DEPTH(STORE_DEPTH),
      .MAX_BATCH  (MAX_BATCH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, what);
   endtask

   // pops one batch of the smallest values if the limit and fill allow it
   function automatic void pop_min_batch();
      int unsigned    k;
      min_result_type r;
      k = (bsize_reg == 0) ? 1 : ((bsize_reg > MAX_BATCH) ? MAX_BATCH : bsize_reg);
      if (batches_left == 0 || sorted_vals.size() < k) return;
      batches_left--;
      for (int j = 0; j < k; j++) begin
         r.value = sorted_vals.pop_front();
         r.last  = (j == k - 1);
         pending_mins.insert(pending_mins.size(), r);
      end
   endfunction

   function automatic void predict_item(req_item_type it);
      logic signed [DATA_W-1:0] v;
      int unsigned              per;
      int unsigned              nxt;
      int                       pos;
      v = it.value;
      if (it.mode == MODE_FLUSH) begin
         n_flushes++;
         pop_min_batch();
         return;
      end
      n_inserts++;
      if (sorted_vals.size() < STORE_DEPTH) begin
         pos = sorted_vals.size();
         while (pos > 0 && sorted_vals[pos-1] > v) pos--;
         sorted_vals.insert(pos, v);
         if (sorted_vals.size() > peak_fill) peak_fill = sorted_vals.size();
      end else begin
         n_dropped++;
      end
      per = (period_reg == 0) ? 1 : period_reg;
      nxt = req_phase + 1;
      if (nxt >= per) begin
         req_phase = '0;
         pop_min_batch();
      end else begin
         req_phase = nxt[PHASE_W-1:0];
      end
   endfunction

   task automatic push_item(input logic mode, input logic [DATA_W-1:0] value);
      req_item_type it;
      it.mode  = mode;
      it.value = value;
      send_q.insert(send_q.size(), it);
   endtask

   // extremes and a narrow band near zero give duplicates and boundary ordering
   function automatic logic [DATA_W-1:0] rand_value();
      case ($urandom_range(9))
         0: return 32'h8000_0000 + $urandom_range(3);
         1: return 32'h7FFF_FFFF - $urandom_range(3);
         2, 3: return $urandom_range(16) - 8;
         default: return $urandom;
      endcase
   endfunction

   task automatic push_random(input int count, input int flush_pct);
      for (int i = 0; i < count; i++)
         push_item(($urandom_range(99) < flush_pct) ? MODE_FLUSH : MODE_INSERT, rand_value());
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [CSR_DW-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_BATCH_SIZE:  bsize_reg = data[BSIZE_W-1:0];
         REG_PERIOD:      period_reg = data[PHASE_W-1:0];
         REG_BATCH_LIMIT: batches_left = data[LIMIT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // an insert gives no result, so allow for the slowest sorted insertion after the last one
   task automatic settle();
      while (send_q.size() != 0 || req_tvalid || pending_mins.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_accepted) begin
         if (send_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
            req_tvalid              <= 1'b1;
            {req_tuser, req_tdata} <= send_q.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (stall_token != stall_seen) begin
         stall_seen <= stall_token;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      min_result_type want;
      if (reset) begin
         req_accepted <= 1'b0;
      end else begin
         req_accepted <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) predict_item({req_tuser, req_tdata});
         if (rsp_tvalid && rsp_tready) begin
            n_results++;
            if (rsp_tlast) n_batches++;
            if (pending_mins.size() == 0) begin
               report_mismatch($sformatf("item %h last=%b with nothing pending",
                                         rsp_tdata, rsp_tlast));
            end else begin
               want = pending_mins.pop_front();
               if (rsp_tdata !== want.value)
                  report_mismatch($sformatf("out_value %h, want %h", rsp_tdata, want.value));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("last %b, want %b (value %h)",
                                            rsp_tlast, want.last, want.value));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
         $display("periodic_batch_min_extractor verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int fill_count;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tuser    = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      bsize_reg    = 1;
      period_reg   = 1;
      req_phase    = '0;
      batches_left = '0;
      calm         = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // out of reset the batch limit is zero: inserts and a flush give nothing
      push_item(MODE_INSERT, 32'h7FFF_FFFF);
      push_item(MODE_INSERT, 32'h8000_0000);
      push_item(MODE_INSERT, 32'h0000_0000);
      push_item(MODE_INSERT, 32'hFFFF_FFFF);
      push_item(MODE_INSERT, 32'h0000_0001);
      push_item(MODE_INSERT, 32'h0000_0000);
      push_item(MODE_FLUSH, 32'hFFFF_FFFF);
      settle();

      // zero batch size and zero period both act as one; three batches only
      csr_write(REG_BATCH_SIZE, 0);
      csr_write(REG_PERIOD, 0);
      csr_write(REG_BATCH_LIMIT, 3);
      push_item(MODE_INSERT, 32'h0000_0005);
      push_item(MODE_INSERT, 32'hFFFF_FFFB);
      push_item(MODE_INSERT, 32'h0000_0007);
      push_item(MODE_INSERT, 32'h0000_0002);
      push_item(MODE_FLUSH, 32'h0000_0000);
      settle();

      // no batches allowed: fill the store, the phase runs far up a long period
      csr_write(REG_BATCH_SIZE, 5);
      csr_write(REG_PERIOD, 16'hFFFF);
      csr_write(REG_BATCH_LIMIT, 0);
      fill_count = STORE_DEPTH - sorted_vals.size();
      push_random(fill_count, 0);
      settle();

      // insert at full store is dropped, yet with the phase past the lowered period
      // it pops an oversized (clamped) batch; then drain until a flush comes up short
      csr_write(REG_BATCH_SIZE, 31);
      csr_write(REG_PERIOD, 3);
      csr_write(REG_BATCH_LIMIT, 16'hFFFF);
      calm = 1'b1;
      push_item(MODE_INSERT, 32'h8000_0000);
      for (int i = 0; i < 16; i++) push_item(MODE_FLUSH, $urandom);
      settle();
      calm = 1'b0;

      csr_write(REG_BATCH_SIZE, 3);
      csr_write(REG_PERIOD, 2);
      csr_write(REG_BATCH_LIMIT, 6);
      push_random(8, 20);
      settle();

      // receiver holds off: a batch stalls in the output register and inserts wait behind it
      csr_write(REG_BATCH_SIZE, 2);
      csr_write(REG_PERIOD, 1);
      csr_write(REG_BATCH_LIMIT, 40);
      stall_token++;
      push_random(12, 10);
      settle();

      $display("covered: %0d inserts (%0d dropped at full store, peak fill %0d), %0d flushes",
               n_inserts, n_dropped, peak_fill, n_flushes);
      $display("covered: %0d values checked in %0d batches, %0d mismatches",
               n_results, n_batches, errors);
      if (errors == 0) begin
         $display("periodic_batch_min_extractor verification clean");
      end else begin
         $display("periodic_batch_min_extractor verification failed");
      end
      $finish;
   end

endmodule
